// ===== rtl/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

    // Phases of the click state machine; codes 6 and 7 are unused.
    typedef enum logic [2:0] {
        PH_WAIT_PRESS   = 3'd0,
        PH_DEB_PRESS    = 3'd1,
        PH_WAIT_RELEASE = 3'd2,
        PH_DEB_RELEASE  = 3'd3,
        PH_WAIT_DOUBLE  = 3'd4,
        PH_TIMEOUT_HOLD = 3'd5
    } t_phase;

    // Event codes reported on the result stream.
    typedef enum logic [2:0] {
        EV_CLICK     = 3'd0,
        EV_DOUBLE    = 3'd1,
        EV_LONG      = 3'd2,
        EV_VERY_LONG = 3'd3,
        EV_TIMEOUT   = 3'd4,
        EV_ERROR     = 3'd5
    } t_event;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LOW_PRESSED      = 3'd0,
        CFG_DEBOUNCE_PRESS   = 3'd1,
        CFG_DEBOUNCE_RELEASE = 3'd2,
        CFG_DOUBLE_WINDOW    = 3'd3,
        CFG_LONG_TIME        = 3'd4,
        CFG_VERY_LONG_TIME   = 3'd5,
        CFG_HOLD_TIMEOUT     = 3'd6
    } t_cfg_idx;

    // Configuration as seen by the state machine.
    typedef struct packed {
        logic        low_pressed;
        logic [15:0] debounce_press;
        logic [15:0] debounce_release;
        logic [15:0] double_window;
        logic [31:0] long_time;
        logic [31:0] very_long_time;
        logic [30:0] hold_timeout;
    } t_cfg;

    localparam logic        RST_LOW_PRESSED      = 1'b1;
    localparam logic [15:0] RST_DEBOUNCE_PRESS   = 16'd50;
    localparam logic [15:0] RST_DEBOUNCE_RELEASE = 16'd50;
    localparam logic [15:0] RST_DOUBLE_WINDOW    = 16'd300;
    localparam logic [31:0] RST_LONG_TIME        = 32'd1000;
    localparam logic [31:0] RST_VERY_LONG_TIME   = 32'd3000;
    localparam logic [30:0] RST_HOLD_TIMEOUT     = 31'd6000;

endpackage

// ===== rtl/bcc_fsm.sv =====
// Click classification state machine: one poll is evaluated per step.
`timescale 1ns / 1ps

module bcc_fsm
    import bcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_level,
    input  logic [31:0] i_now,
    input  t_cfg        i_cfg,
    output logic        o_emit,
    output t_event      o_event
);

    t_phase      r_phase,        n_phase;
    logic [31:0] r_press_start,  n_press_start;
    logic [31:0] r_last_mark,    n_last_mark;
    logic        r_second_click, n_second_click;

    logic        pressed;
    logic [31:0] since_press;
    logic [31:0] since_mark;

    always_comb begin
        pressed     = (i_level == ~i_cfg.low_pressed);
        since_press = i_now - r_press_start;
        since_mark  = i_now - r_last_mark;

        n_phase        = r_phase;
        n_press_start  = r_press_start;
        n_last_mark    = r_last_mark;
        n_second_click = r_second_click;
        o_emit         = 1'b0;
        o_event        = EV_CLICK;

        unique case (r_phase)
            PH_WAIT_PRESS: begin
                if (pressed) begin
                    n_press_start = i_now;
                    n_phase       = PH_DEB_PRESS;
                end
            end
            PH_DEB_PRESS: begin
                if (since_press > {16'd0, i_cfg.debounce_press}) begin
                    n_phase = pressed ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!pressed) begin
                    if (since_press > i_cfg.very_long_time) begin
                        n_phase = PH_WAIT_PRESS;
                        o_emit  = 1'b1;
                        o_event = EV_VERY_LONG;
                    end else if (since_press > i_cfg.long_time) begin
                        n_phase = PH_WAIT_PRESS;
                        o_emit  = 1'b1;
                        o_event = EV_LONG;
                    end else begin
                        n_last_mark = i_now;
                        n_phase     = PH_DEB_RELEASE;
                    end
                end else if (since_press > {1'b0, i_cfg.hold_timeout}) begin
                    n_phase     = PH_TIMEOUT_HOLD;
                    n_last_mark = i_now;
                end
            end
            PH_DEB_RELEASE: begin
                // The level is not checked again once the release settles.
                if (since_mark > {16'd0, i_cfg.debounce_release}) begin
                    n_phase = PH_WAIT_DOUBLE;
                end
            end
            PH_WAIT_DOUBLE: begin
                if (pressed && !r_second_click) begin
                    // The second press keeps the first press start time.
                    n_last_mark    = i_now;
                    n_second_click = 1'b1;
                    n_phase        = PH_DEB_PRESS;
                end else if (since_mark > {16'd0, i_cfg.double_window}) begin
                    n_phase = PH_WAIT_PRESS;
                    o_emit  = 1'b1;
                    if (r_second_click) begin
                        n_second_click = 1'b0;
                        o_event        = EV_DOUBLE;
                    end else begin
                        o_event = EV_CLICK;
                    end
                end
            end
            PH_TIMEOUT_HOLD: begin
                if (!pressed) begin
                    if (since_mark > {16'd0, i_cfg.debounce_release}) begin
                        n_last_mark = i_now;
                        n_phase     = PH_WAIT_PRESS;
                        o_emit      = 1'b1;
                        o_event     = EV_TIMEOUT;
                    end
                end else begin
                    n_last_mark = i_now;
                    if (since_press > {i_cfg.hold_timeout, 1'b0}) begin
                        n_phase = PH_WAIT_PRESS;
                        o_emit  = 1'b1;
                        o_event = EV_ERROR;
                    end
                end
            end
            default: begin
                n_phase = PH_WAIT_PRESS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT_PRESS;
            r_press_start  <= 32'd0;
            r_last_mark    <= 32'd0;
            r_second_click <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_press_start  <= n_press_start;
            r_last_mark    <= n_last_mark;
            r_second_click <= n_second_click;
        end
    end

endmodule

// ===== rtl/button_click_classifier_core.sv =====
// Top level of the button click classifier: stream ports, registers, pipeline.
`timescale 1ns / 1ps

// Each input item is one poll of a push button: the raw pin level and a
// millisecond timestamp that wraps modulo 2^32. The block debounces presses
// and releases and reports a click, double click, long click, very long
// click, a timeout after a long hold, or an error when the button stays held
// past twice the hold timeout; a poll that completes no gesture yields no
// result item. An item is registered on entry, evaluated by the state
// machine from the input register, and its event, if any, lands in the
// output register, so one item is taken every cycle while the output
// is not stalled. The input stage stalls only while the output
// register holds a result that the consumer has not taken. Configuration
// writes take effect at the next edge and are meant to happen while no poll
// is in flight.

module button_click_classifier_core
    import bcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // Poll stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [0] level, [32:1] now_ms, [39:33] zero
    // Event stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [2:0] event_res, [7:3] zero
);

    t_cfg        r_cfg;

    // Input register.
    logic        r_in_valid;
    logic        r_in_level;
    logic [31:0] r_in_now;

    // Output register.
    logic        r_out_valid;
    t_event      r_out_event;

    logic        advance;
    logic        fsm_emit;
    t_event      fsm_event;

    // Configuration registers; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_pressed      <= RST_LOW_PRESSED;
            r_cfg.debounce_press   <= RST_DEBOUNCE_PRESS;
            r_cfg.debounce_release <= RST_DEBOUNCE_RELEASE;
            r_cfg.double_window    <= RST_DOUBLE_WINDOW;
            r_cfg.long_time        <= RST_LONG_TIME;
            r_cfg.very_long_time   <= RST_VERY_LONG_TIME;
            r_cfg.hold_timeout     <= RST_HOLD_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LOW_PRESSED:      r_cfg.low_pressed      <= i_cfg_data[0];
                CFG_DEBOUNCE_PRESS:   r_cfg.debounce_press   <= i_cfg_data[15:0];
                CFG_DEBOUNCE_RELEASE: r_cfg.debounce_release <= i_cfg_data[15:0];
                CFG_DOUBLE_WINDOW:    r_cfg.double_window    <= i_cfg_data[15:0];
                CFG_LONG_TIME:        r_cfg.long_time        <= i_cfg_data;
                CFG_VERY_LONG_TIME:   r_cfg.very_long_time   <= i_cfg_data;
                CFG_HOLD_TIMEOUT:     r_cfg.hold_timeout     <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // The registered item moves through the state machine whenever the
    // output register is empty or is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_level <= i_s_tdata[0];
            r_in_now   <= i_s_tdata[32:1];
        end
    end

    bcc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_level (r_in_level),
        .i_now   (r_in_now),
        .i_cfg   (r_cfg),
        .o_emit  (fsm_emit),
        .o_event (fsm_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fsm_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && fsm_emit) begin
            r_out_event <= fsm_event;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_event};

endmodule

// ===== rtl/bcc_checker.sv =====
// Port-level assertions for the button click classifier and their binding.
`timescale 1ns / 1ps

module bcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata
);

    // Only the six defined event codes may leave the block.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:3] == 5'd0) && (o_m_tdata[2:0] <= 3'd5))
        else $error("undefined event code on result stream");

    // A waiting result stays put until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // The poll side stalls only behind a result the consumer is not taking.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
